// ===== rtl/mbe_pkg.sv =====
// Package for the multilinear basis evaluator: item structs, pipeline
// control structs, register indexes and chain numbering.
// No dependencies; every other file of the block uses it.
package mbe_pkg;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int INDEX_W  = 3;
  localparam int NUM_DIMS = 3;
  localparam int NUM_CHAINS = NUM_DIMS + 1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPACE_DIMS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLY_DEGREE = 2'd1;

  localparam logic [1:0] DIMS_RESET   = 2'd3;
  localparam logic       DEGREE_RESET = 1'b1;

  // Product chains: the basis value first, then one chain per gradient component.
  localparam int CH_VALUE = 0;
  localparam int CH_GRAD0 = 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        basis_index;
    logic signed [COORD_W-1:0] basis_value;
    logic signed [COORD_W-1:0] grad_x;
    logic signed [COORD_W-1:0] grad_y;
    logic signed [COORD_W-1:0] grad_z;
    logic                      last_basis;
  } out_item_t;

  // What travels beside the partial products through the multiply stages.
  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic                last;
    logic [NUM_DIMS-1:0] gmask;
    logic                sel_last;
    logic [COORD_W-1:0]  fac_last;
  } ctrl_t;

  // One issued basis function: its selected factors and control.
  typedef struct packed {
    logic                              vld;
    logic [NUM_DIMS-1:0][COORD_W-1:0]  fac;
    logic [NUM_DIMS-1:0]               sel;
    logic [NUM_DIMS-1:0]               gmask;
    logic [INDEX_W-1:0]                index;
    logic                              last;
  } issue_t;

endpackage

// ===== rtl/mbe_issue.sv =====
// Input holding register and basis sequencer of the multilinear basis evaluator.
// Forms the per-dimension factors and issues one basis function per cycle while adv is high.
// Depends on mbe_pkg.
module mbe_issue #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_DIMS  = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mbe_pkg::in_item_t in_data,
  input  logic [1:0]        space_dims,
  input  logic              poly_degree,
  input  logic              adv,
  output mbe_pkg::issue_t   iss
);

  localparam int SUM_W = mbe_pkg::DIFF_W + 2;
  localparam logic signed [mbe_pkg::COORD_W-1:0] ONE =
    mbe_pkg::COORD_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) << (mbe_pkg::COORD_W - 1));
  localparam logic [1:0] DIMS_CAP = 2'(MAX_DIMS);

  logic                                              hold_vld;
  logic [mbe_pkg::NUM_DIMS-1:0][mbe_pkg::DIFF_W-1:0] diff;
  logic [mbe_pkg::INDEX_W-1:0]                       k;

  logic [1:0]                                        dims;
  logic [mbe_pkg::INDEX_W-1:0]                       last_k;
  logic                                              take;
  logic                                              done;
  logic [mbe_pkg::NUM_DIMS-1:0][mbe_pkg::COORD_W-1:0] fac_next;
  logic [mbe_pkg::NUM_DIMS-1:0]                      sel_next;
  logic [mbe_pkg::NUM_DIMS-1:0]                      gmask_next;

  always_comb begin
    if (space_dims == 2'd0) begin
      dims = 2'd1;
    end else if (space_dims > DIMS_CAP) begin
      dims = DIMS_CAP;
    end else begin
      dims = space_dims;
    end
    if (!poly_degree) begin
      last_k = '0;
    end else begin
      case (dims)
        2'd1:    last_k = 3'd1;
        2'd2:    last_k = 3'd3;
        default: last_k = 3'd7;
      endcase
    end
  end

  assign take     = hold_vld && adv;
  assign done     = take && (k == last_k);
  assign in_ready = !hold_vld || done;

  // Factor for each dimension: 0.5 - d or 0.5 + d, saturated; unused dimensions
  // and degree zero contribute 1.0, which leaves a product unchanged.
  always_comb begin
    logic [1:0]               bitpos;
    logic signed [SUM_W-1:0]  dext;
    logic signed [SUM_W-1:0]  sum;
    for (int dd = 0; dd < mbe_pkg::NUM_DIMS; dd++) begin
      bitpos = 2'(dims - 2'(dd) - 2'd1);
      dext   = SUM_W'($signed(diff[dd]));
      sum    = '0;
      sel_next[dd]   = 1'b0;
      fac_next[dd]   = ONE;
      gmask_next[dd] = poly_degree && (2'(dd) < dims);
      if (gmask_next[dd]) begin
        sel_next[dd] = k[bitpos];
        sum = sel_next[dd] ? (HALF + dext) : (HALF - dext);
        if (sum > SAT_MAX) begin
          fac_next[dd] = SAT_MAX[mbe_pkg::COORD_W-1:0];
        end else if (sum < SAT_MIN) begin
          fac_next[dd] = SAT_MIN[mbe_pkg::COORD_W-1:0];
        end else begin
          fac_next[dd] = sum[mbe_pkg::COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
      k        <= '0;
      iss.vld  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_vld <= 1'b1;
      end else if (done) begin
        hold_vld <= 1'b0;
      end
      if (take) begin
        k <= done ? '0 : 3'(k + 3'd1);
      end
      if (adv) begin
        iss.vld <= hold_vld;
      end
    end
    if (in_valid && in_ready) begin
      diff[0] <= mbe_pkg::DIFF_W'(in_data.point_x) - mbe_pkg::DIFF_W'(in_data.center_x);
      diff[1] <= mbe_pkg::DIFF_W'(in_data.point_y) - mbe_pkg::DIFF_W'(in_data.center_y);
      diff[2] <= mbe_pkg::DIFF_W'(in_data.point_z) - mbe_pkg::DIFF_W'(in_data.center_z);
    end
    if (adv) begin
      iss.fac   <= fac_next;
      iss.sel   <= sel_next;
      iss.gmask <= gmask_next;
      iss.index <= k;
      iss.last  <= (k == last_k);
    end
  end

endmodule

// ===== rtl/mbe_mul_stage.sv =====
// One multiply step of the four product chains: Q-format multiply, floor
// shift and saturation to 32 bits, registered. Depends on mbe_pkg.
module mbe_mul_stage #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                en,
  input  logic                                                in_vld,
  input  logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] a,
  input  logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] b,
  input  mbe_pkg::ctrl_t                                      in_ctrl,
  output logic                                                out_vld,
  output logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] p,
  output mbe_pkg::ctrl_t                                      out_ctrl
);

  localparam int PROD_W = 2 * mbe_pkg::COORD_W;
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32'sh7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(1) << (mbe_pkg::COORD_W - 1));

  logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] p_next;

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;
    for (int c = 0; c < mbe_pkg::NUM_CHAINS; c++) begin
      prod    = $signed(a[c]) * $signed(b[c]);
      // An arithmetic right shift rounds toward minus infinity.
      shifted = prod >>> FRAC_BITS;
      if (shifted > SAT_MAX) begin
        p_next[c] = SAT_MAX[mbe_pkg::COORD_W-1:0];
      end else if (shifted < SAT_MIN) begin
        p_next[c] = SAT_MIN[mbe_pkg::COORD_W-1:0];
      end else begin
        p_next[c] = shifted[mbe_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p        <= p_next;
      out_ctrl <= in_ctrl;
    end
  end

endmodule

// ===== rtl/multilinear_basis_eval.sv =====
// Top level of the multilinear basis evaluator.
// Depends on mbe_pkg, mbe_issue and mbe_mul_stage.
//
// Usage: each input item carries a point and a cell center in signed
// fixed point with FRAC_BITS fraction bits. For every basis function of the
// multilinear basis on that cell the block returns one output item holding
// the basis index, the value and the gradient, with last_basis set on the
// final one. Degree one gives 2^dims items per input item, degree zero one.
// The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// space_dims at index 0 and poly_degree at index 1; cfg_ready is always high
// and writes are expected only while the block is idle.
// The first output item of an input item passes the holding register, the
// issue stage and two multiply stages. The sequencer issues one basis
// function per cycle while the pipeline is not stalled, so an input item
// holds the block until all its basis functions are issued. The next input
// item is accepted in the cycle the last basis function of the current one
// is issued, so items stream without gaps.
// Reset clears all valid bits and sets space_dims to 3 and poly_degree to 1.
// When the receiver holds out_ready low while out_valid is high, the whole
// pipeline freezes and out_data holds its item; nothing is dropped or repeated.
module multilinear_basis_eval #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_DIMS  = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mbe_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mbe_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic signed [mbe_pkg::COORD_W-1:0] ONE =
    mbe_pkg::COORD_W'(1) << FRAC_BITS;

  // Configuration registers.
  logic [1:0] space_dims;
  logic       poly_degree;

  // Pipeline state.
  logic                                                adv;
  mbe_pkg::issue_t                                     iss;
  logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] a1;
  logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] b1;
  mbe_pkg::ctrl_t                                      ctrl1;
  logic                                                vld2;
  logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] p2;
  mbe_pkg::ctrl_t                                      ctrl2;
  logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] b2;
  logic                                                vld3;
  logic [mbe_pkg::NUM_CHAINS-1:0][mbe_pkg::COORD_W-1:0] p3;
  mbe_pkg::ctrl_t                                      ctrl3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      space_dims  <= mbe_pkg::DIMS_RESET;
      poly_degree <= mbe_pkg::DEGREE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbe_pkg::CFG_SPACE_DIMS:  space_dims  <= cfg_data[1:0];
        mbe_pkg::CFG_POLY_DEGREE: poly_degree <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless the output item is stalled.
  assign adv = !vld3 || out_ready;

  mbe_issue #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_issue (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .space_dims  (space_dims),
    .poly_degree (poly_degree),
    .adv         (adv),
    .iss         (iss)
  );

  // First multiply: the product starts at 1.0, and multiplying 1.0 by a
  // saturated factor gives that factor, so each chain begins with its first
  // dimension's factor and multiplies by the second. In the gradient chain of
  // a dimension, that dimension's factor becomes -1.0 or +1.0.
  always_comb begin
    a1[mbe_pkg::CH_VALUE] = iss.fac[0];
    b1[mbe_pkg::CH_VALUE] = iss.fac[1];
    for (int g = 0; g < mbe_pkg::NUM_DIMS; g++) begin
      a1[mbe_pkg::CH_GRAD0 + g] = (g == 0) ? (iss.sel[0] ? ONE : -ONE) : iss.fac[0];
      b1[mbe_pkg::CH_GRAD0 + g] = (g == 1) ? (iss.sel[1] ? ONE : -ONE) : iss.fac[1];
    end
    ctrl1.index    = iss.index;
    ctrl1.last     = iss.last;
    ctrl1.gmask    = iss.gmask;
    ctrl1.sel_last = iss.sel[2];
    ctrl1.fac_last = iss.fac[2];
  end

  mbe_mul_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul_a (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (iss.vld),
    .a        (a1),
    .b        (b1),
    .in_ctrl  (ctrl1),
    .out_vld  (vld2),
    .p        (p2),
    .out_ctrl (ctrl2)
  );

  // Second multiply by the third dimension's factor. A gradient component of
  // a dimension not in use, or any at degree zero, is multiplied by zero, which clears it.
  always_comb begin
    b2[mbe_pkg::CH_VALUE] = ctrl2.fac_last;
    for (int g = 0; g < mbe_pkg::NUM_DIMS; g++) begin
      if (!ctrl2.gmask[g]) begin
        b2[mbe_pkg::CH_GRAD0 + g] = '0;
      end else if (g == 2) begin
        b2[mbe_pkg::CH_GRAD0 + g] = ctrl2.sel_last ? ONE : -ONE;
      end else begin
        b2[mbe_pkg::CH_GRAD0 + g] = ctrl2.fac_last;
      end
    end
  end

  mbe_mul_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul_b (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vld2),
    .a        (p2),
    .b        (b2),
    .in_ctrl  (ctrl2),
    .out_vld  (vld3),
    .p        (p3),
    .out_ctrl (ctrl3)
  );

  assign out_valid            = vld3;
  assign out_data.basis_index = ctrl3.index;
  assign out_data.basis_value = p3[mbe_pkg::CH_VALUE];
  assign out_data.grad_x      = p3[mbe_pkg::CH_GRAD0];
  assign out_data.grad_y      = p3[mbe_pkg::CH_GRAD0 + 1];
  assign out_data.grad_z      = p3[mbe_pkg::CH_GRAD0 + 2];
  assign out_data.last_basis  = ctrl3.last;

endmodule

// ===== rtl/mbe_checker.sv =====
// Port-level checker for the multilinear basis evaluator, bound to the top level.
// Depends on mbe_pkg and multilinear_basis_eval.
module mbe_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input mbe_pkg::out_item_t out_data
);

  // A stalled output item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // Right after the last result of a point, any result starts a new point.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_basis |=>
      !out_valid || out_data.basis_index == '0)
    else $error("new point did not start at basis index zero");

  // Results of one point come out in order with no gaps in the index.
  a_in_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_basis |=>
      !out_valid || out_data.basis_index == 3'($past(out_data.basis_index) + 3'd1))
    else $error("basis index skipped or repeated");

  // Basis index seven is always the final result of its point.
  a_max_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.basis_index == 3'd7 |-> out_data.last_basis)
    else $error("basis index seven not marked last");

endmodule

bind multilinear_basis_eval mbe_checker u_mbe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
